@@ hdl/rmq_pkg.sv @@
// shared types and constants for the rotation matrix to quaternion pipeline
package rmq_pkg;

    localparam int FIELD_W       = 18;
    localparam int FRAC_BITS_DEF = 16;
    // magnitude of a sum or difference of two fields
    localparam int MAG_W         = FIELD_W + 1;
    localparam longint FIELD_MAX = 131071;
    localparam longint FIELD_MIN_MAG = 131072;

    typedef enum logic [3:0] {
        BR_TRACE = 4'b0001,
        BR_X     = 4'b0010,
        BR_Y     = 4'b0100,
        BR_Z     = 4'b1000
    } t_branch;

    // numerators and branch that ride along with the root
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        t_branch               br;
    } t_side;

endpackage

@@ hdl/rotation_matrix_to_quaternion.sv @@
// rotation matrix to quaternion converter, fully pipelined
//
// Input channel: i_valid / o_ready with the nine Q1.16 matrix elements i_m00..i_m22.
// Output channel: o_valid / i_ready with o_q_real, o_q_i, o_q_j, o_q_k, saturated
// to plus or minus one.
// One matrix is taken every cycle while the output is not held. The root pipeline has
// one square root stage per root bit (RTW, the root width) and each divider one
// restoring division stage per quotient bit (NW, the quotient width).
// Stage 1 picks the branch and forms the radicand and three numerators, then the
// root pipeline, a stage that forms the rounded dividends, three parallel divider
// pipelines, and an output register that also maps and saturates the components.
// The whole pipe advances together: when the output beat is held by a low
// i_ready, every stage holds and o_ready drops, so nothing is lost or repeated.
// Empty stages hold too while the output waits, so bubbles are not squeezed out.
// Reset (i_rst_n low, synchronous) clears all valid bits; the block
// accepts a beat in the first cycle after reset is released.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m00,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m01,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m02,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m10,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m11,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m12,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m20,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m21,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m22,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_real,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_i,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_j,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_q_k
);

    localparam int FW   = rmq_pkg::FIELD_W;
    localparam int MW   = rmq_pkg::MAG_W;
    localparam int XW   = ((FRAC_BITS + 1 > FW) ? FRAC_BITS + 1 : FW) + 3;
    localparam int RW   = XW - 1 + FRAC_BITS;
    localparam int RTW  = (RW + 1) / 2;
    localparam int DW   = RTW + 1;
    localparam int NW   = MW + FRAC_BITS + 1;
    localparam int AW   = DW + NW;
    localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
    localparam longint PMAX  = (ONE_L < rmq_pkg::FIELD_MAX) ? ONE_L : rmq_pkg::FIELD_MAX;
    localparam longint NMAX  = (ONE_L < rmq_pkg::FIELD_MIN_MAG) ? ONE_L
                                                                : rmq_pkg::FIELD_MIN_MAG;

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // ---------------- stage 1: branch, radicand, numerators ----------------
    logic signed [XW-1:0] x00, x11, x22, trace, rad_x;
    logic signed [MW-1:0] num [3];
    rmq_pkg::t_side       n_side;
    logic [RW-1:0]        n_rad;

    always_comb begin
        x00   = XW'(i_m00);
        x11   = XW'(i_m11);
        x22   = XW'(i_m22);
        trace = x00 + x11 + x22;
        if (trace > 0) begin
            n_side.br = rmq_pkg::BR_TRACE;
            rad_x     = trace + XW'(ONE_L);
            num[0]    = MW'(i_m21) - MW'(i_m12);
            num[1]    = MW'(i_m02) - MW'(i_m20);
            num[2]    = MW'(i_m10) - MW'(i_m01);
        end else if (i_m00 > i_m11 && i_m00 > i_m22) begin
            n_side.br = rmq_pkg::BR_X;
            rad_x     = XW'(ONE_L) + x00 - x11 - x22;
            num[0]    = MW'(i_m21) - MW'(i_m12);
            num[1]    = MW'(i_m01) + MW'(i_m10);
            num[2]    = MW'(i_m02) + MW'(i_m20);
        end else if (i_m11 > i_m22) begin
            n_side.br = rmq_pkg::BR_Y;
            rad_x     = XW'(ONE_L) + x11 - x00 - x22;
            num[0]    = MW'(i_m02) - MW'(i_m20);
            num[1]    = MW'(i_m01) + MW'(i_m10);
            num[2]    = MW'(i_m12) + MW'(i_m21);
        end else begin
            n_side.br = rmq_pkg::BR_Z;
            rad_x     = XW'(ONE_L) + x22 - x00 - x11;
            num[0]    = MW'(i_m10) - MW'(i_m01);
            num[1]    = MW'(i_m02) + MW'(i_m20);
            num[2]    = MW'(i_m12) + MW'(i_m21);
        end
        for (int n = 0; n < 3; n++) begin
            n_side.neg[n] = num[n][MW-1];
            n_side.mag[n] = num[n][MW-1] ? MW'(-num[n]) : MW'(num[n]);
        end
        // non-positive radicand gives a zero root
        n_rad = (rad_x > 0) ? {rad_x[XW-2:0], {FRAC_BITS{1'b0}}} : '0;
    end

    // ---------------- square root pipeline ----------------
    logic                r_sq_v    [0:RTW];
    logic [RW:0]         r_sq_rem  [0:RTW];
    logic [RW:0]         r_sq_root [0:RTW];
    rmq_pkg::t_side      r_sq_side [0:RTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (adv) begin
            r_sq_v[0] <= i_valid;
        end
        if (adv) begin
            r_sq_rem[0]  <= (RW+1)'(n_rad);
            r_sq_root[0] <= '0;
            r_sq_side[0] <= n_side;
        end
    end

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        localparam logic [RW:0] BIT = (RW+1)'(1) << (2 * (RTW - 1 - k));
        logic [RW:0] cand, n_rem, n_root;

        always_comb begin
            cand = r_sq_root[k] + BIT;
            if (r_sq_rem[k] >= cand) begin
                n_rem  = r_sq_rem[k] - cand;
                n_root = (r_sq_root[k] >> 1) + BIT;
            end else begin
                n_rem  = r_sq_rem[k];
                n_root = r_sq_root[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            if (adv) begin
                r_sq_rem[k+1]  <= n_rem;
                r_sq_root[k+1] <= n_root;
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    // ---------------- divider pipelines ----------------
    logic [RTW-1:0]  root;
    assign root = r_sq_root[RTW][RTW-1:0];

    logic                  r_dv_v    [0:NW];
    logic [RTW-1:0]        r_dv_root [0:NW];
    rmq_pkg::t_side        r_dv_side [0:NW];
    logic [2:0][AW-1:0]    r_dv_acc  [0:NW];

    // dividend is (mag << frac) + root, which rounds the quotient by 2*root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (adv) begin
            r_dv_v[0] <= r_sq_v[RTW];
        end
        if (adv) begin
            r_dv_root[0] <= root;
            r_dv_side[0] <= r_sq_side[RTW];
            for (int n = 0; n < 3; n++) begin
                r_dv_acc[0][n] <= AW'({r_sq_side[RTW].mag[n], {FRAC_BITS{1'b0}}})
                                  + AW'(root);
            end
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [DW-1:0]      den;
        logic [2:0][AW-1:0] n_acc;

        always_comb begin
            logic [AW:0] sh;
            logic [DW:0] hi;
            logic [DW:0] diff;
            den = {r_dv_root[k], 1'b0};
            for (int n = 0; n < 3; n++) begin
                sh   = {r_dv_acc[k][n], 1'b0};
                hi   = sh[AW:NW];
                diff = hi - (DW+1)'(den);
                if (hi >= (DW+1)'(den)) begin
                    n_acc[n] = {diff[DW-1:0], sh[NW-1:1], 1'b1};
                end else begin
                    n_acc[n] = {hi[DW-1:0], sh[NW-1:0]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            if (adv) begin
                r_dv_root[k+1] <= r_dv_root[k];
                r_dv_side[k+1] <= r_dv_side[k];
                r_dv_acc[k+1]  <= n_acc;
            end
        end
    end

    // ---------------- output mapping and saturation ----------------
    function automatic logic [FW-1:0] sat(input logic [NW-1:0] mag, input logic neg);
        longint m;
        m = longint'({{(64-NW){1'b0}}, mag});
        if (neg) begin
            if (m > NMAX) m = NMAX;
            m = -m;
        end else begin
            if (m > PMAX) m = PMAX;
        end
        return m[FW-1:0];
    endfunction

    logic [NW-1:0]      half, quo [3];
    logic [3:0][NW-1:0] comp_mag;
    logic [3:0]         comp_neg;
    rmq_pkg::t_side     fin_side;
    logic [FW-1:0]      n_q [4];

    always_comb begin
        fin_side = r_dv_side[NW];
        half     = NW'((NW'(r_dv_root[NW]) + NW'(1)) >> 1);
        for (int n = 0; n < 3; n++) begin
            // zero divisor gives zero quotients
            quo[n] = (r_dv_root[NW] == '0) ? '0 : r_dv_acc[NW][n][NW-1:0];
        end
        // component order: real, i, j, k
        unique case (fin_side.br)
            rmq_pkg::BR_TRACE: begin
                comp_mag = {quo[2], quo[1], quo[0], half};
                comp_neg = {fin_side.neg[2], fin_side.neg[1], fin_side.neg[0], 1'b0};
            end
            rmq_pkg::BR_X: begin
                comp_mag = {quo[2], quo[1], half, quo[0]};
                comp_neg = {fin_side.neg[2], fin_side.neg[1], 1'b0, fin_side.neg[0]};
            end
            rmq_pkg::BR_Y: begin
                comp_mag = {quo[2], half, quo[1], quo[0]};
                comp_neg = {fin_side.neg[2], 1'b0, fin_side.neg[1], fin_side.neg[0]};
            end
            rmq_pkg::BR_Z: begin
                comp_mag = {half, quo[2], quo[1], quo[0]};
                comp_neg = {1'b0, fin_side.neg[2], fin_side.neg[1], fin_side.neg[0]};
            end
            default: begin
                comp_mag = '0;
                comp_neg = '0;
            end
        endcase
        for (int c = 0; c < 4; c++) begin
            n_q[c] = sat(comp_mag[c], comp_neg[c]);
        end
    end

    logic [FW-1:0] r_q [4];
    logic          r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_dv_v[NW];
        end
        if (adv) begin
            r_q <= n_q;
        end
    end

    assign o_valid  = r_out_v;
    assign o_q_real = signed'(r_q[0]);
    assign o_q_i    = signed'(r_q[1]);
    assign o_q_j    = signed'(r_q[2]);
    assign o_q_k    = signed'(r_q[3]);

endmodule

@@ dv/rotation_matrix_to_quaternion_test.sv @@
// testbench for the rotation matrix to quaternion converter
module rotation_matrix_to_quaternion_test;

    localparam int FB = rmq_pkg::FRAC_BITS_DEF;
    localparam int FIELD_W = rmq_pkg::FIELD_W;
    localparam longint FIELD_MAX = rmq_pkg::FIELD_MAX;
    localparam longint FIELD_MIN_MAG = rmq_pkg::FIELD_MIN_MAG;
    localparam longint ONE = longint'(1) << FB;
    localparam int LATENCY = 60;
    localparam int N_RANDOM = 1500;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [FIELD_W-1:0] t_fx;
    typedef struct {
        t_fx m [9];
    } t_matrix;
    typedef struct {
        t_fx qr, qi, qj, qk;
    } t_quat;

    // one row of the directed table; has_exp marks rows with a typed-in result
    typedef struct {
        t_matrix mat;
        bit      has_exp;
        t_quat   q;
    } t_row;

    logic i_clk, i_rst_n, i_valid, i_ready;
    logic o_ready, o_valid;
    t_fx i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22;
    t_fx o_q_real, o_q_i, o_q_j, o_q_k;

    rotation_matrix_to_quaternion DUT (.*);

    t_quat quat_expected [$];
    int mismatch_count = 0;
    bit stim_done = 0;
    bit hold_long = 0;
    longint cycle_count = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint root_of(longint x);
        if (x <= 0) return 0;
        return int_sqrt(longint'(x) << FB);
    endfunction

    // rounded (num << FB) / (2*root), ties away from zero
    function automatic longint quot_of(longint num, longint root);
        longint mag, den, q;
        if (root == 0) return 0;
        den = root * 2;
        mag = (num < 0) ? -num : num;
        q = ((mag << FB) + root) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_fx clamp_fx(longint v);
        if (v > ONE) v = ONE;
        if (v < -ONE) v = -ONE;
        if (v > FIELD_MAX) v = FIELD_MAX;
        if (v < -FIELD_MIN_MAG) v = -FIELD_MIN_MAG;
        return t_fx'(v);
    endfunction

    function automatic t_quat quaternion_of(t_matrix mt);
        longint a [9];
        longint tr, rt, qr, qi, qj, qk;
        t_quat q;
        foreach (a[n]) a[n] = longint'(mt.m[n]);
        tr = a[0] + a[4] + a[8];
        if (tr > 0) begin
            rt = root_of(tr + ONE);
            qi = quot_of(a[7] - a[5], rt);
            qj = quot_of(a[2] - a[6], rt);
            qk = quot_of(a[3] - a[1], rt);
            qr = (rt + 1) >> 1;
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            rt = root_of(ONE + a[0] - a[4] - a[8]);
            qi = (rt + 1) >> 1;
            qj = quot_of(a[1] + a[3], rt);
            qk = quot_of(a[2] + a[6], rt);
            qr = quot_of(a[7] - a[5], rt);
        end else if (a[4] > a[8]) begin
            rt = root_of(ONE + a[4] - a[0] - a[8]);
            qi = quot_of(a[1] + a[3], rt);
            qj = (rt + 1) >> 1;
            qk = quot_of(a[5] + a[7], rt);
            qr = quot_of(a[2] - a[6], rt);
        end else begin
            rt = root_of(ONE + a[8] - a[0] - a[4]);
            qi = quot_of(a[2] + a[6], rt);
            qj = quot_of(a[5] + a[7], rt);
            qk = (rt + 1) >> 1;
            qr = quot_of(a[3] - a[1], rt);
        end
        q.qr = clamp_fx(qr);
        q.qi = clamp_fx(qi);
        q.qj = clamp_fx(qj);
        q.qk = clamp_fx(qk);
        return q;
    endfunction

    function automatic t_matrix diag_matrix(longint d0, longint d1, longint d2, longint off);
        t_matrix mt;
        foreach (mt.m[n]) mt.m[n] = t_fx'(off);
        mt.m[0] = t_fx'(d0);
        mt.m[4] = t_fx'(d1);
        mt.m[8] = t_fx'(d2);
        return mt;
    endfunction

    function automatic t_fx rand_field();
        case ($urandom_range(0, 9))
            0: return t_fx'($urandom);                       // any pattern
            1: return t_fx'(ONE);
            2: return t_fx'(-ONE);
            3: return t_fx'($urandom_range(0, 3)) - 1;
            default: return t_fx'(longint'($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    // rotation-like: perturbed signed permutation, or all fields random
    function automatic t_matrix rand_matrix();
        t_matrix mt;
        int perm [3];
        int s, tmp;
        if ($urandom_range(0, 3) == 0) begin
            foreach (mt.m[n]) mt.m[n] = rand_field();
            return mt;
        end
        perm = '{0, 1, 2};
        for (int n = 2; n > 0; n--) begin
            s = $urandom_range(0, n);
            tmp = perm[n];
            perm[n] = perm[s];
            perm[s] = tmp;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
                longint v;
                v = longint'($urandom_range(0, 40000)) - 20000;
                if (perm[r] == c)
                    v = ($urandom_range(0, 1) ? ONE : -ONE) - (v < 0 ? v : -v) *
                        ($urandom_range(0, 1) ? 1 : -1);
                mt.m[3 * r + c] = clamp_fx(v);
            end
        return mt;
    endfunction

    // valid drops only for an idle gap, so back to back beats keep it high
    task automatic send_matrix(t_matrix mt);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} <=
            {mt.m[0], mt.m[1], mt.m[2], mt.m[3], mt.m[4], mt.m[5], mt.m[6], mt.m[7], mt.m[8]};
        do @(posedge i_clk); while (!o_ready);
    endtask

    // expectation is queued at the accepting edge so it precedes the result
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_valid && o_ready) begin
            t_matrix mt;
            mt.m = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};
            quat_expected.push_back(quaternion_of(mt));
        end
        if (i_rst_n && o_valid && i_ready) begin
            t_quat e;
            if (quat_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected beat at cycle %0d", cycle_count);
            end else begin
                e = quat_expected.pop_front();
                if (e.qr !== o_q_real || e.qi !== o_q_i || e.qj !== o_q_j || e.qk !== o_q_k) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 e.qr, e.qi, e.qj, e.qk, o_q_real, o_q_i, o_q_j, o_q_k);
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_long = 0;
            end
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        t_row rows [$];
        t_row rw;
        t_quat pq;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity: real part one
        rw.mat = diag_matrix(ONE, ONE, ONE, 0); rw.has_exp = 1;
        rw.q = '{t_fx'(ONE), 0, 0, 0}; rows.push_back(rw);
        // 180 degrees about each axis
        rw.mat = diag_matrix(ONE, -ONE, -ONE, 0); rw.q = '{0, t_fx'(ONE), 0, 0};
        rows.push_back(rw);
        rw.mat = diag_matrix(-ONE, ONE, -ONE, 0); rw.q = '{0, 0, t_fx'(ONE), 0};
        rows.push_back(rw);
        rw.mat = diag_matrix(-ONE, -ONE, ONE, 0); rw.q = '{0, 0, 0, t_fx'(ONE)};
        rows.push_back(rw);
        // all zero: trace not positive, radicand one via z branch
        rw.mat = diag_matrix(0, 0, 0, 0); rw.has_exp = 0; rows.push_back(rw);
        // equal negative diagonal: z branch by tie
        rw.mat = diag_matrix(-ONE, -ONE, -ONE, 0); rows.push_back(rw);
        rw.mat = diag_matrix(-FIELD_MIN_MAG, -FIELD_MIN_MAG, -FIELD_MIN_MAG, FIELD_MAX);
        rows.push_back(rw);
        // diagonal ties
        rw.mat = diag_matrix(-ONE / 2, -ONE / 2, -ONE / 2, 1000); rows.push_back(rw);
        rw.mat = diag_matrix(0, 0, -ONE, 2000); rows.push_back(rw);
        rw.mat = diag_matrix(0, -ONE, 0, -2000); rows.push_back(rw);
        rw.mat = diag_matrix(-ONE, 0, 0, 3000); rows.push_back(rw);
        // trace exactly zero and one above
        rw.mat = diag_matrix(ONE, -ONE, 0, 500); rows.push_back(rw);
        rw.mat = diag_matrix(ONE, -ONE, 1, -500); rows.push_back(rw);
        // field extremes, saturation
        rw.mat = diag_matrix(FIELD_MAX, FIELD_MAX, FIELD_MAX, -FIELD_MIN_MAG); rows.push_back(rw);
        rw.mat = diag_matrix(FIELD_MAX, -FIELD_MIN_MAG, -FIELD_MIN_MAG, FIELD_MAX);
        rows.push_back(rw);
        rw.mat = diag_matrix(-FIELD_MIN_MAG, FIELD_MAX, -FIELD_MIN_MAG, -FIELD_MIN_MAG);
        rows.push_back(rw);
        rw.mat = diag_matrix(1, 1, 1, FIELD_MAX); rows.push_back(rw);
        rw.mat = diag_matrix(-1, -1, -1, -1); rows.push_back(rw);

        @(posedge i_clk);
        foreach (rows[n]) begin
            send_matrix(rows[n].mat);
            if (rows[n].has_exp) begin
                pq = quaternion_of(rows[n].mat);
                if (pq.qr !== rows[n].q.qr || pq.qi !== rows[n].q.qi ||
                    pq.qj !== rows[n].q.qj || pq.qk !== rows[n].q.qk) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("table row %0d: exp %0d %0d %0d %0d predicted %0d %0d %0d %0d",
                                 n, rows[n].q.qr, rows[n].q.qi, rows[n].q.qj, rows[n].q.qk,
                                 pq.qr, pq.qi, pq.qj, pq.qk);
                end
            end
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) hold_long = 1;
            send_matrix(rand_matrix());
        end
        i_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        @(posedge i_clk iff (stim_done && quat_expected.size() == 0) || cycle_count > CYCLE_LIMIT);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rotation_matrix_to_quaternion test failed");
            $finish;
        end else begin
            repeat (LATENCY) @(posedge i_clk);
            if (mismatch_count == 0 && quat_expected.size() == 0)
                $display("rotation_matrix_to_quaternion test passed");
            else
                $display("rotation_matrix_to_quaternion test failed");
            $finish;
        end
    end

endmodule
